@@ src/hfsc_pkg.sv @@
// Shared types and constants for the half-float scale and clamp pipeline.
package hfsc_pkg;

   localparam logic [30:0] SCALE_RESET = 31'd1053410813;
   localparam logic [15:0] HALF_POS_ZERO = 16'h0000;
   localparam logic [15:0] HALF_NEG_ZERO = 16'h8000;
   localparam logic [15:0] HALF_POS_INF = 16'h7C00;
   localparam logic [15:0] HALF_NEG_INF = 16'hFC00;
   localparam logic [4:0] HALF_EXP_MAX = 5'h1F;
   localparam logic [7:0] SGL_EXP_MAX = 8'hFF;
   localparam logic [7:0] EXP_REBIAS = 8'd112;
   localparam logic signed [9:0] SGL_BIAS = 10'sd127;
   localparam logic signed [9:0] HALF_REBIAS = 10'sd112;

   // Stage 1: unpacked operands, or a result already settled by the operand classes.
   typedef struct packed {
      logic special;
      logic [15:0] spec_val;
      logic neg;
      logic [10:0] sig_x;
      logic [23:0] sig_s;
      logic signed [9:0] exp_sum;
   } unp_type;

   // Stage 2: raw significand product.
   typedef struct packed {
      logic special;
      logic [15:0] spec_val;
      logic neg;
      logic [34:0] prod;
      logic signed [9:0] exp_sum;
   } mul_type;

   // Stage 3: product rounded to single precision.
   typedef struct packed {
      logic special;
      logic [15:0] spec_val;
      logic [23:0] mant;
      logic signed [9:0] exp_b;
   } rnd_type;

endpackage

@@ src/hfsc_unpack.sv @@
// Stage 1: widens the half input, classifies both operands and settles special cases.
module hfsc_unpack (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic valid_in,
   input  logic [15:0] half_in,
   input  logic [30:0] scale,
   output logic valid_ff,
   output hfsc_pkg::unp_type data_ff
);
   import hfsc_pkg::*;

   unp_type data_in;
   logic sx, x_zero, x_inf, x_nan, s_zero, s_sub, s_inf, s_nan;
   logic [4:0] ehx;
   logic [9:0] mx;
   logic [7:0] es, ex;
   logic [22:0] ms;
   logic [3:0] msb;
   logic [4:0] msb_s;
   logic signed [9:0] es_eff;

   always_comb begin
      sx = half_in[15];
      ehx = half_in[14:10];
      mx = half_in[9:0];
      es = scale[30:23];
      ms = scale[22:0];
      x_zero = (ehx == 5'd0) && (mx == 10'd0);
      x_inf = (ehx == HALF_EXP_MAX) && (mx == 10'd0);
      x_nan = (ehx == HALF_EXP_MAX) && (mx != 10'd0);
      s_zero = (es == 8'd0) && (ms == 23'd0);
      s_sub = (es == 8'd0) && (ms != 23'd0);
      s_inf = (es == SGL_EXP_MAX) && (ms == 23'd0);
      s_nan = (es == SGL_EXP_MAX) && (ms != 23'd0);
      msb = 4'd0;
      for (int i = 0; i < 10; i++) begin
         if (mx[i]) begin
            msb = 4'(i);
         end
      end
      msb_s = 5'd0;
      for (int i = 0; i < 23; i++) begin
         if (ms[i]) begin
            msb_s = 5'(i);
         end
      end
      if (ehx == 5'd0) begin
         ex = 8'd103 + {4'd0, msb};
         data_in.sig_x = {1'b0, mx} << (4'd10 - msb);
      end else begin
         ex = {3'd0, ehx} + EXP_REBIAS;
         data_in.sig_x = {1'b1, mx};
      end
      // subnormal scale is normalized so the product keeps its exact exponent
      if (s_sub) begin
         es_eff = $signed({5'd0, msb_s}) - 10'sd22;
         data_in.sig_s = {1'b0, ms} << (5'd23 - msb_s);
      end else begin
         es_eff = $signed({2'b00, es});
         data_in.sig_s = {1'b1, ms};
      end
      data_in.exp_sum = $signed({2'b00, ex}) + es_eff - SGL_BIAS;
      data_in.neg = sx;
      data_in.special = 1'b1;
      if (x_nan || s_nan || (x_inf && s_zero) || (x_zero && s_inf)) begin
         data_in.spec_val = sx ? HALF_NEG_INF : HALF_POS_INF;
      end else if (x_inf || s_inf) begin
         data_in.spec_val = sx ? HALF_POS_ZERO : HALF_POS_INF;
      end else if (x_zero || s_zero) begin
         data_in.spec_val = sx ? HALF_NEG_ZERO : HALF_POS_ZERO;
      end else begin
         data_in.special = 1'b0;
         data_in.spec_val = HALF_POS_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

endmodule

@@ src/hfsc_mul.sv @@
// Stage 2: 11 x 24 bit significand multiply.
module hfsc_mul (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic valid_in,
   input  hfsc_pkg::unp_type data_in,
   output logic valid_ff,
   output hfsc_pkg::mul_type data_ff
);
   import hfsc_pkg::*;

   mul_type next_in;

   always_comb begin
      next_in.special = data_in.special;
      next_in.spec_val = data_in.spec_val;
      next_in.neg = data_in.neg;
      next_in.prod = {24'd0, data_in.sig_x} * {11'd0, data_in.sig_s};
      next_in.exp_sum = data_in.exp_sum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= next_in;
      end
   end

endmodule

@@ src/hfsc_round.sv @@
// Stage 3: normalizes the product, rounds to nearest even at 24 bits and clamps negative products to zero.
module hfsc_round (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic valid_in,
   input  hfsc_pkg::mul_type data_in,
   output logic valid_ff,
   output hfsc_pkg::rnd_type data_ff
);
   import hfsc_pkg::*;

   rnd_type next_in;
   logic [23:0] m;
   logic guard, sticky, rnd, tiny;
   logic [24:0] sum;
   logic signed [9:0] e;

   always_comb begin
      if (data_in.prod[34]) begin
         m = data_in.prod[34:11];
         guard = data_in.prod[10];
         sticky = |data_in.prod[9:0];
         e = data_in.exp_sum + 10'sd1;
      end else begin
         m = data_in.prod[33:10];
         guard = data_in.prod[9];
         sticky = |data_in.prod[8:0];
         e = data_in.exp_sum;
      end
      rnd = guard && (sticky || m[0]);
      sum = {1'b0, m} + {24'd0, rnd};
      // exact product at or below 2^-150 rounds to zero in single precision
      tiny = (e < -10'sd23) ||
             ((e == -10'sd23) && (m == 24'h800000) && !guard && !sticky);
      next_in.special = data_in.special;
      next_in.spec_val = data_in.spec_val;
      if (data_in.neg && !data_in.special) begin
         // negative product: -0 if it rounds to zero, otherwise clamped to +0
         next_in.special = 1'b1;
         next_in.spec_val = tiny ? HALF_NEG_ZERO : HALF_POS_ZERO;
      end
      if (sum[24]) begin
         next_in.mant = 24'h800000;
         next_in.exp_b = e + 10'sd1;
      end else begin
         next_in.mant = sum[23:0];
         next_in.exp_b = e;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= next_in;
      end
   end

endmodule

@@ src/hfsc_pack.sv @@
// Stage 4: truncating narrow to half precision, into the output register.
module hfsc_pack (
   input  logic clock,
   input  logic reset,
   input  logic en,
   input  logic valid_in,
   input  hfsc_pkg::rnd_type data_in,
   output logic valid_ff,
   output logic [15:0] half_ff
);
   import hfsc_pkg::*;

   logic [15:0] half_in;
   logic signed [9:0] eh;
   logic [4:0] sh;
   logic [23:0] shifted;

   always_comb begin
      eh = data_in.exp_b - HALF_REBIAS;
      sh = 5'(10'sd14 - eh);
      shifted = data_in.mant >> sh;
      if (data_in.special) begin
         half_in = data_in.spec_val;
      end else if (eh < -10'sd10) begin
         half_in = HALF_POS_ZERO;
      end else if (eh <= 10'sd0) begin
         half_in = {6'd0, shifted[9:0]};
      end else if (eh == 10'sd31) begin
         // exponent field all ones keeps its mantissa bits
         half_in = HALF_POS_INF | {6'd0, data_in.mant[22:13]};
      end else if (eh > 10'sd31) begin
         half_in = HALF_POS_INF;
      end else begin
         half_in = {1'b0, eh[4:0], data_in.mant[22:13]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         half_ff <= half_in;
      end
   end

endmodule

@@ src/half_float_scale_clamp_core.sv @@
// Each accepted req passes the unpack, multiply, round and pack stage registers in order to rsp_valid.
// Throughput: one item per cycle while rsp_ready is high; each stage moves on when it is empty or the next one moves.
// The 11 x 24 significand multiply sets the stage depth.
// Reset clears all stage valid bits and loads the scale register with 80/203.
module half_float_scale_clamp_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [15:0] req_component_in,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [15:0] rsp_component_out,
   input  logic csr_wr_en,
   input  logic [30:0] csr_wr_data
);
   import hfsc_pkg::*;

   logic [30:0] scale_ff;
   logic v1, v2, v3;
   logic rdy1, rdy2, rdy3, rdy4;
   unp_type d1;
   mul_type d2;
   rnd_type d3;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         scale_ff <= csr_wr_data;
      end
   end

   assign rdy4 = !rsp_valid || rsp_ready;
   assign rdy3 = !v3 || rdy4;
   assign rdy2 = !v2 || rdy3;
   assign rdy1 = !v1 || rdy2;
   assign req_ready = rdy1;

   hfsc_unpack u_unpack (
      .clock(clock), .reset(reset), .en(rdy1), .valid_in(req_valid),
      .half_in(req_component_in), .scale(scale_ff), .valid_ff(v1), .data_ff(d1)
   );

   hfsc_mul u_mul (
      .clock(clock), .reset(reset), .en(rdy2), .valid_in(v1),
      .data_in(d1), .valid_ff(v2), .data_ff(d2)
   );

   hfsc_round u_round (
      .clock(clock), .reset(reset), .en(rdy3), .valid_in(v2),
      .data_in(d2), .valid_ff(v3), .data_ff(d3)
   );

   hfsc_pack u_pack (
      .clock(clock), .reset(reset), .en(rdy4), .valid_in(v3),
      .data_in(d3), .valid_ff(rsp_valid), .half_ff(rsp_component_out)
   );

endmodule

@@ src/hfsc_checker.sv @@
// Port-level checks for the half-float scale and clamp core, bound to the top level.
module hfsc_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [15:0] rsp_component_out
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_component_out))
      else $error("stalled rsp item changed");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output");

   // negative results only as -0 or from a NaN product
   a_neg_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_component_out[15] |->
         rsp_component_out == 16'h8000 || rsp_component_out == 16'hFC00)
      else $error("negative result not clamped");

endmodule

bind half_float_scale_clamp_core hfsc_checker u_hfsc_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready), .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready), .rsp_component_out(rsp_component_out)
);

@@ test/testbench.sv @@
// Testbench for the half-float scale and clamp pipeline: predicts each result and checks it.
`timescale 1ns / 1ps

class fp16_scale_scoreboard;
   logic [30:0] scale;
   logic [15:0] expected_q[$];
   int errors;

   function new();
      scale = hfsc_pkg::SCALE_RESET;
      errors = 0;
   endfunction

   // Widen to single, multiply with round-to-nearest-even, clamp, narrow by truncation.
   function logic [15:0] scale_component(logic [15:0] h);
      logic sgn;
      logic [10:0] mm;
      logic [31:0] xb, rb;
      logic [7:0] xe, se;
      logic [22:0] xm, sm, nm;
      logic [23:0] ma, mb, nm24;
      logic [63:0] prod, q, rem, hf;
      int k, ea, eb, ex, n, biased, sh, ne;
      logic x_nan, s_nan, x_inf, s_inf, x_zero, s_zero;
      sgn = h[15];
      mm = {1'b0, h[9:0]};
      if (h[14:10] == 5'd0 && mm == 11'd0) begin
         xb = {sgn, 31'd0};
      end else if (h[14:10] == 5'd0) begin
         k = 0;
         while (!mm[10]) begin
            mm = mm << 1;
            k++;
         end
         xb = {sgn, 8'(113 - k), mm[9:0], 13'd0};
      end else if (h[14:10] == hfsc_pkg::HALF_EXP_MAX) begin
         xb = {sgn, hfsc_pkg::SGL_EXP_MAX, h[9:0], 13'd0};
      end else begin
         xb = {sgn, 8'(h[14:10]) + hfsc_pkg::EXP_REBIAS, h[9:0], 13'd0};
      end
      xe = xb[30:23];
      xm = xb[22:0];
      se = scale[30:23];
      sm = scale[22:0];
      x_nan = xe == 8'hFF && xm != 0;
      s_nan = se == 8'hFF && sm != 0;
      x_inf = xe == 8'hFF && xm == 0;
      s_inf = se == 8'hFF && sm == 0;
      x_zero = xe == 0 && xm == 0;
      s_zero = se == 0 && sm == 0;
      if (x_nan || s_nan || (x_inf && s_zero) || (s_inf && x_zero))
         return {sgn, 15'h7C00};
      if (x_inf || s_inf) begin
         rb = {sgn, 8'hFF, 23'd0};
      end else if (x_zero || s_zero) begin
         rb = {sgn, 31'd0};
      end else begin
         ma = {xe != 0, xm};
         mb = {se != 0, sm};
         ea = (xe == 0) ? 1 : int'(xe);
         eb = (se == 0) ? 1 : int'(se);
         prod = 64'(ma) * 64'(mb);
         ex = ea + eb - 300;
         n = 0;
         for (int i = 0; i < 48; i++)
            if (prod[i]) n = i;
         biased = n + ex + 127;
         sh = (biased >= 1) ? n - 23 : -(ex + 149);
         if (sh <= 0) begin
            q = prod << (-sh);
         end else if (sh > 60) begin
            q = 0;
         end else begin
            q = prod >> sh;
            rem = prod & ((64'd1 << sh) - 1);
            hf = 64'd1 << (sh - 1);
            if (rem > hf || (rem == hf && q[0])) q++;
         end
         if (biased >= 1) begin
            if (q[24]) begin
               q = q >> 1;
               biased++;
            end
            if (biased >= 255) rb = {sgn, 8'hFF, 23'd0};
            else rb = {sgn, 8'(biased), q[22:0]};
         end else begin
            // rounding up to 2^23 lands on the smallest normal, which the encoding handles
            rb = {sgn, q[30:0]};
         end
      end
      if (rb[31] && rb[30:0] != 0) rb = 32'd0;
      ne = int'(rb[30:23]) - 112;
      nm = rb[22:0];
      if (ne <= 0) begin
         if (ne < -10) return {rb[31], 15'd0};
         nm24 = {1'b1, nm} >> (1 - ne);
         return {rb[31], 15'(nm24 >> 13)};
      end
      if (ne >= 31) begin
         if (ne == 31 && nm != 0) return {rb[31], 5'h1F, nm[22:13]};
         return {rb[31], 15'h7C00};
      end
      return {rb[31], 5'(ne), nm[22:13]};
   endfunction

   function void note_component(logic [15:0] h);
      expected_q.push_back(scale_component(h));
   endfunction

   task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch: %s got %h expected %h", what, got, want);
      errors++;
   endtask

   task check_component(logic [15:0] got);
      logic [15:0] want;
      if (expected_q.size() == 0) begin
         report_mismatch("unexpected item", got, 16'h0);
      end else begin
         want = expected_q.pop_front();
         if (got !== want) report_mismatch("component_out", got, want);
      end
   endtask
endclass

module testbench;
   import hfsc_pkg::*;

   localparam int IDLE_LIMIT = 1000;
   localparam int HOLD_CYCLES = 300;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [15:0] req_component_in = 0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic [15:0] rsp_component_out;
   logic csr_wr_en = 0;
   logic [30:0] csr_wr_data = 0;

   fp16_scale_scoreboard sb = new();
   logic hold_trig = 0;
   logic hold_seen = 0;
   int hold_left = 0;
   int stall_mode = 0;
   int idle_cycles = 0;

   always #1 clock = ~clock;

   half_float_scale_clamp_core u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_component_in(req_component_in),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_component_out(rsp_component_out),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   // receiver: own stall pattern, plus a long hold-off when asked
   always @(negedge clock) begin
      if (hold_trig != hold_seen) begin
         hold_seen <= hold_trig;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else begin
         case (stall_mode)
            0: rsp_ready <= 1;
            1: rsp_ready <= $urandom_range(0, 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_component(rsp_component_out);
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // called at a falling edge; leaves valid high for a following item
   task send_component(logic [15:0] h);
      req_valid = 1;
      req_component_in = h;
      do @(posedge clock); while (!req_ready);
      sb.note_component(h);
      @(negedge clock);
   endtask

   task pause_sender(int n);
      req_valid = 0;
      repeat (n) @(negedge clock);
   endtask

   task drain_results();
      req_valid = 0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task write_scale(logic [30:0] value);
      csr_wr_en = 1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 0;
      sb.scale = value;
   endtask

   function logic [15:0] random_component();
      logic [15:0] h;
      h = 16'($urandom);
      case ($urandom_range(0, 9))
         6: h[14:10] = 5'd0;
         7: h[14:10] = HALF_EXP_MAX;
         8: h[14:10] = ($urandom_range(0, 1)) ? 5'd30 : 5'd1;
         9: h[14:10] = 5'($urandom_range(0, 4));
         default: ;
      endcase
      return h;
   endfunction

   logic [15:0] directed[] = '{16'h0000, 16'h8000, 16'h0001, 16'h8001, 16'h03FF, 16'h0400,
      16'h7BFF, 16'hFBFF, 16'h7C00, 16'hFC00, 16'h7C01, 16'h7E00, 16'hFFFF, 16'h3C00,
      16'hBC00, 16'h3555, 16'h0200, 16'h5BFF, 16'h7800, 16'hAAAA, 16'h5555};
   logic [30:0] scales[$] = '{SCALE_RESET, 31'h40000000, 31'h3F800000, 31'h00000000,
      31'h7F7FFFFF, 31'h00000001, 31'h7F800000, 31'h7FFFFFFF, 31'h7FC00000, 31'h47800000};

   initial begin
      repeat (7) @(negedge clock);
      reset = 0;
      repeat (4) scales.push_back({1'b0, 8'($urandom_range(100, 150)), 23'($urandom)});
      foreach (scales[p]) begin
         if (p != 0) write_scale(scales[p]);
         stall_mode = p % 3;
         foreach (directed[i]) send_component(directed[i]);
         for (int i = 0; i < 86; i++) begin
            if (p == 2 && i == 10) hold_trig = ~hold_trig;
            send_component(random_component());
            if (p % 4 != 0 && $urandom_range(0, 7) == 0) pause_sender($urandom_range(1, 20));
         end
         drain_results();
      end
      repeat (20) @(negedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

@@ sim.f @@
src/hfsc_pkg.sv
src/hfsc_unpack.sv
src/hfsc_mul.sv
src/hfsc_round.sv
src/hfsc_pack.sv
src/half_float_scale_clamp_core.sv
src/hfsc_checker.sv
test/testbench.sv
